// ===== sv/bapd_pkg.sv =====
// ----------------------------------------------------------------------------
// bapd_pkg
// Shared constants and types for the bitmap/attribute screen pixel decoder.
// ----------------------------------------------------------------------------
package bapd_pkg;

  localparam int unsigned OffW     = 13;
  localparam int unsigned AddrW    = 15;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned SDataW   = 40;
  localparam int unsigned MDataW   = 56;

  localparam int unsigned ScrBytes = 6912;

  localparam logic [OffW-1:0] ScrEnd     = 13'd6912;
  localparam logic [OffW-1:0] AttrBase   = 13'd6144;
  localparam logic [7:0]      LevelBright = 8'hFF;
  localparam logic [7:0]      LevelNormal = 8'hD8;
  localparam logic [7:0]      DarkBlack   = 8'd63;

  localparam logic [1:0] AddrBaseHi = 2'b10;

  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqRender = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgCursorCol = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCursorRow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHighlight = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== sv/bapd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bapd_ctrl
// Request sequencer: takes one request, waits for the store read, then loads
// the result register when it is free.
// ----------------------------------------------------------------------------
module bapd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output bapd_pkg::ctrl_cmd_t   cmd_o,
  output bapd_pkg::ctrl_status_t status_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   load_out;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out = (state_q == S_CALC) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CALC;
      end
      S_CALC: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (load_out)        out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign cmd_o.accept      = accept;
  assign cmd_o.load_out    = load_out;
  assign status_o.out_free = out_free;

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CALC))
    else $error("accepted request did not move to calc");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid_o)
    else $error("result load did not raise valid");

  a_calc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CALC) && !out_free) |=> ((state_q == S_CALC) && m_axis_tvalid_o))
    else $error("calc left while result register busy");

  a_no_accept_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> !accept)
    else $error("request taken while another is pending");

endmodule

// ===== sv/bapd_dp.sv =====
// ----------------------------------------------------------------------------
// bapd_dp
// Screen store, address formation, colour decode, config and result register.
// ----------------------------------------------------------------------------
module bapd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bapd_pkg::ctrl_cmd_t               cmd_i,
  input  logic                              req_type_i,
  input  logic [bapd_pkg::OffW-1:0]         write_addr_i,
  input  logic [7:0]                        write_byte_i,
  input  logic [7:0]                        px_x_i,
  input  logic [7:0]                        px_y_i,
  input  logic                              cfg_we_i,
  input  logic [bapd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bapd_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic [bapd_pkg::MDataW-1:0]       m_tdata_o
);

  logic [7:0] screen_q [bapd_pkg::ScrBytes];

  logic                       req_q;
  logic [7:0]                 x_q, y_q;
  logic                       bm_ok_q, at_ok_q;
  logic [7:0]                 bm_rd_q, at_rd_q;
  logic [4:0]                 cur_col_q, cur_row_q;
  logic                       hl_en_q;
  logic [bapd_pkg::MDataW-1:0] out_q;

  logic [bapd_pkg::OffW-1:0] bm_off_in, at_off_in;
  logic [bapd_pkg::OffW-1:0] bm_off, at_off;
  logic                      do_write, do_read;
  logic                      pix;
  logic [7:0]                attr;
  logic [2:0]                col;
  logic [7:0]                level, black;
  logic                      in_cursor;
  logic [7:0]                r, g, b;
  logic [bapd_pkg::MDataW-1:0] result;

  assign bm_off_in = {px_y_i[7:6], px_y_i[2:0], px_y_i[5:3], px_x_i[7:3]};
  assign at_off_in = bapd_pkg::AttrBase + {3'b000, px_y_i[7:3], px_x_i[7:3]};

  assign do_write = cmd_i.accept && (req_type_i == bapd_pkg::ReqWrite)
                    && (write_addr_i < bapd_pkg::ScrEnd);
  assign do_read  = cmd_i.accept && (req_type_i == bapd_pkg::ReqRender);

  always_ff @(posedge clk_i) begin
    if (do_write) screen_q[write_addr_i] <= write_byte_i;
    if (do_read && (bm_off_in < bapd_pkg::ScrEnd)) bm_rd_q <= screen_q[bm_off_in];
    if (do_read && (at_off_in < bapd_pkg::ScrEnd)) at_rd_q <= screen_q[at_off_in];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_type_i;
      x_q     <= px_x_i;
      y_q     <= px_y_i;
      bm_ok_q <= (bm_off_in < bapd_pkg::ScrEnd);
      at_ok_q <= (at_off_in < bapd_pkg::ScrEnd);
    end
    if (cmd_i.load_out) out_q <= result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      hl_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bapd_pkg::CfgCursorCol: cur_col_q <= cfg_data_i;
        bapd_pkg::CfgCursorRow: cur_row_q <= cfg_data_i;
        bapd_pkg::CfgHighlight: hl_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign bm_off = {y_q[7:6], y_q[2:0], y_q[5:3], x_q[7:3]};
  assign at_off = bapd_pkg::AttrBase + {3'b000, y_q[7:3], x_q[7:3]};

  always_comb begin
    pix       = bm_ok_q && bm_rd_q[~x_q[2:0]];
    attr      = at_ok_q ? at_rd_q : 8'h00;
    in_cursor = hl_en_q && (x_q[7:3] == cur_col_q) && (y_q[7:3] == cur_row_q);
    level     = attr[6] ? bapd_pkg::LevelBright : bapd_pkg::LevelNormal;
    black     = 8'h00;
    if (in_cursor) begin
      level = {1'b0, level[7:1]};
      black = bapd_pkg::DarkBlack;
    end
    col = pix ? attr[2:0] : attr[5:3];
    if (col != 3'b000) black = 8'h00;
    r = col[1] ? level : black;
    g = col[2] ? level : black;
    b = col[0] ? level : black;
    if (req_q == bapd_pkg::ReqWrite) begin
      result = '0;
    end else begin
      result = {1'b0, pix, bapd_pkg::AddrBaseHi, at_off,
                bapd_pkg::AddrBaseHi, bm_off, r, g, b};
    end
  end

  assign m_tdata_o = out_q;

endmodule

// ===== sv/bitmap_attr_screen_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// bitmap_attr_screen_pixel_decoder
// Screen image store with bitmap/attribute pixel colour decode.
//
// Channel  Dir  Handshake                      Content
// s_axis   in   s_axis_tvalid_i/tready_o       write byte or render request
// m_axis   out  m_axis_tvalid_o/tready_i       colour, addresses, pixel bit
// cfg      in   cfg_valid_i/cfg_ready_o        cursor and highlight registers
//
// Each request first reads its bitmap and attribute bytes from the dual-read
// store, then decodes them into the result register.
// The next request is taken while a result waits on m_axis; a stalled output
// holds the decoder in its decode step until the result register drains.
// Reset clears control state and the cursor registers and enables highlight; the store is not cleared.
// ----------------------------------------------------------------------------
module bitmap_attr_screen_pixel_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [12:0] write_addr, [20:13] write_byte, [28:21] px_x, [36:29] px_y
  input  logic [bapd_pkg::SDataW-1:0]       s_axis_tdata_i,
  // [0] req_type
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [23:0] rgb_colour, [38:24] bitmap_address, [53:39] attribute_address,
  // [54] pixel_set
  output logic [bapd_pkg::MDataW-1:0]       m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bapd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bapd_pkg::CfgDataW-1:0]     cfg_data_i
);

  bapd_pkg::ctrl_cmd_t    cmd;
  bapd_pkg::ctrl_status_t status;
  logic                   cfg_we;
  logic                   unused_status;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign unused_status = status.out_free;

  bapd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd),
    .status_o        (status)
  );

  bapd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (s_axis_tuser_i),
    .write_addr_i (s_axis_tdata_i[12:0]),
    .write_byte_i (s_axis_tdata_i[20:13]),
    .px_x_i       (s_axis_tdata_i[28:21]),
    .px_y_i       (s_axis_tdata_i[36:29]),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .m_tdata_o    (m_axis_tdata_o)
  );

endmodule
